[hw/rtl/lsq_pkg.sv]
// Package: shared types and constants for the LIFO stack with scan queries.
package lsq_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int WORD_W    = 32;
	localparam int CNT_W     = 7;

	typedef enum logic [1:0] {
		MODE_PUSH   = 2'd0,
		MODE_POP    = 2'd1,
		MODE_MAXMIN = 2'd2,
		MODE_COUNT  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		FAULT_NONE  = 2'd0,
		FAULT_EMPTY = 2'd1,
		FAULT_FULL  = 2'd2
	} fault_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic clear;
		logic valid;
	} acc_ctl_t;

endpackage

[hw/rtl/lsq_mem.sv]
// Stack storage: one write port, one read port with registered read data.
module lsq_mem
	import lsq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [WORD_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/lsq_acc.sv]
// Scan accumulator: running signed max, min and match count over streamed entries.
module lsq_acc
	import lsq_pkg::*;
#(
	parameter int CW = CNT_W
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  acc_ctl_t                 ctl,
	input  logic signed [WORD_W-1:0] data,
	input  logic signed [WORD_W-1:0] key,
	output logic signed [WORD_W-1:0] max_val,
	output logic signed [WORD_W-1:0] min_val,
	output logic [CW-1:0]            match_cnt
);

	logic first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (ctl.clear) begin
			first_q <= 1'b1;
		end else if (ctl.valid) begin
			first_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			match_cnt <= '0;
		end else if (ctl.valid) begin
			if (first_q || data > max_val) begin
				max_val <= data;
			end
			if (first_q || data < min_val) begin
				min_val <= data;
			end
			match_cnt <= match_cnt + CW'(data == key);
		end
	end

endmodule

[hw/rtl/lifo_stack_with_scan_queries.sv]
// Top level: LIFO stack of signed words with max/min and match-count scan queries.
//
// Input channel s_*: one transfer per operation. s_tuser holds the mode (push, pop,
// max/min query, count query), s_tdata holds the word to push or to count.
// Output channel m_*: exactly one result transfer per input transfer, in order.
// m_tuser holds the fault code, m_tdata the popped word or maximum, the minimum,
// the match count and the depth after the operation.
// Push and any operation on an empty stack go from ST_IDLE to ST_EMIT, pop passes
// through ST_POP, and the scan queries pass through ST_SCAN, where they read every
// stored entry once through the single RAM read port.
// One operation is in flight at a time, so a new operation is taken only after
// the last one has left ST_EMIT for the output register.
// s_tready is high whenever no operation is being worked on, also while a
// finished result waits in the output register.
// A stalled receiver holds the result in the output register; the next operation
// is taken and worked on, and its result waits until the register frees.
// Reset empties the stack; the RAM contents are not cleared and need not be,
// since only entries below the current depth are ever read.
module lifo_stack_with_scan_queries
	import lsq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // value[31:0]
	input  logic [1:0]  s_tuser,   // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // result_value[31:0], result_min[63:32],
	                               // match_count[70:64], depth_now[77:71], zero pad
	output logic [1:0]  m_tuser    // fault[1:0]
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	state_t state_q, state_d;

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic              rd_vld_s1;
	mode_t             mode_q;
	fault_t            fault_q;
	logic [WORD_W-1:0] key_q;
	logic [WORD_W-1:0] pop_q;

	logic              m_tvalid_q;
	logic [79:0]       m_tdata_q;
	logic [1:0]        m_tuser_q;

	logic              in_xfer;
	mode_t             in_mode;
	logic              empty;
	logic              full;
	logic              scan_more;
	logic              out_free;
	logic              out_load;

	logic              mem_we;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [WORD_W-1:0] mem_rdata;

	acc_ctl_t          acc_ctl;
	logic signed [WORD_W-1:0] acc_max;
	logic signed [WORD_W-1:0] acc_min;
	logic [CW-1:0]     acc_matches;

	logic [WORD_W-1:0] res_val;
	logic [WORD_W-1:0] res_min;
	logic [CNT_W-1:0]  res_matches;

	assign in_xfer   = s_tvalid && s_tready;
	assign in_mode   = mode_t'(s_tuser);
	assign empty     = (count_q == '0);
	assign full      = (count_q == CW'(DEPTH));
	assign scan_more = (idx_q != count_q);
	assign out_free  = !m_tvalid_q || m_tready;

	lsq_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (count_q[AW-1:0]),
		.wdata (s_tdata[WORD_W-1:0]),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	lsq_acc #(
		.CW (CW)
	) u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (acc_ctl),
		.data      (mem_rdata),
		.key       (key_q),
		.max_val   (acc_max),
		.min_val   (acc_min),
		.match_cnt (acc_matches)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					unique case (in_mode) inside
						MODE_PUSH: state_d = ST_EMIT;
						MODE_POP: state_d = empty ? ST_EMIT : ST_POP;
						MODE_MAXMIN, MODE_COUNT: state_d = empty ? ST_EMIT : ST_SCAN;
						default: state_d = ST_EMIT;
					endcase
				end
			end
			ST_POP: state_d = ST_EMIT;
			ST_SCAN: begin
				if (!scan_more && !rd_vld_s1) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready      = (state_q == ST_IDLE);
		mem_we        = 1'b0;
		mem_re        = 1'b0;
		mem_raddr     = idx_q[AW-1:0];
		acc_ctl.clear = in_xfer;
		acc_ctl.valid = rd_vld_s1;
		out_load      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				mem_we    = in_xfer && (in_mode == MODE_PUSH) && !full;
				mem_re    = in_xfer && (in_mode == MODE_POP) && !empty;
				mem_raddr = AW'(count_q - 1'b1);
			end
			ST_POP: begin
			end
			ST_SCAN: begin
				mem_re = scan_more;
			end
			ST_EMIT: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			mode_q    <= MODE_PUSH;
			fault_q   <= FAULT_NONE;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == ST_SCAN) && scan_more;
			if (in_xfer) begin
				idx_q  <= '0;
				mode_q <= in_mode;
				case (in_mode)
					MODE_PUSH: begin
						fault_q <= full ? FAULT_FULL : FAULT_NONE;
						if (!full) begin
							count_q <= count_q + 1'b1;
						end
					end
					MODE_POP: begin
						fault_q <= empty ? FAULT_EMPTY : FAULT_NONE;
						if (!empty) begin
							count_q <= count_q - 1'b1;
						end
					end
					MODE_MAXMIN: fault_q <= empty ? FAULT_EMPTY : FAULT_NONE;
					default: fault_q <= FAULT_NONE;
				endcase
			end else if (state_q == ST_SCAN && scan_more) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			key_q <= s_tdata[WORD_W-1:0];
			pop_q <= '0;
		end else if (state_q == ST_POP) begin
			pop_q <= mem_rdata;
		end
	end

	always_comb begin
		res_val     = '0;
		res_min     = '0;
		res_matches = '0;
		case (mode_q)
			MODE_POP: res_val = pop_q;
			MODE_MAXMIN: begin
				if (fault_q == FAULT_NONE) begin
					res_val = acc_max;
					res_min = acc_min;
				end
			end
			MODE_COUNT: res_matches = CNT_W'(acc_matches);
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {2'b00, CNT_W'(count_q), res_matches, res_min, res_val};
			m_tuser_q <= fault_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
